// ===== rtl/core/kcbm_pkg.sv =====
// package for the key chord binding matcher: sizes, codes and control structs
`timescale 1ns / 1ps
`default_nettype none
package kcbm_pkg;

  localparam int NUM_BINDINGS = 16;
  localparam int MAX_CHORD    = 4;
  localparam int KEY_SPACE    = 1024;

  localparam int KEY_W      = 10;
  localparam int KEY_FIELDS = 4;
  localparam int SLOT_OUT_W = 4;
  localparam int WORD_W     = 64;
  localparam int BIT_W      = 6;

  typedef enum logic [1:0] {
    OP_KEY    = 2'd0,
    OP_BIND   = 2'd1,
    OP_UNBIND = 2'd2,
    OP_CLEAR  = 2'd3
  } op_kind_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } ev_kind_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_FOUND  = 2'd1,
    ST_TABLE_FULL = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_KEY_RD,
    S_KEY_WR,
    S_SC_SLOT,
    S_CK_KEY,
    S_CK_HELD,
    S_CK_EVAL,
    S_SC_UPD,
    S_SC_NEXT,
    S_CLR,
    S_FD_SLOT,
    S_FD_KEY,
    S_FD_CMP,
    S_FD_DEC,
    S_FD_NEXT,
    S_ED_REL,
    S_ED_MISS,
    S_BD_WR,
    S_BD_ACT,
    S_FIN
  } state_e;

  typedef struct packed {
    logic     load;
    logic     held_rd_ck;
    logic     held_wr;
    logic     chk_start;
    logic     eval_held;
    logic     eval_match;
    logic     idx_inc;
    logic     slot_inc;
    logic     upd_active;
    logic     clr_entry;
    logic     emit;
    ev_kind_e emit_kind;
    logic     take_free;
    logic     set_not_found;
    logic     set_full;
    logic     bind_wr;
    logic     bind_commit;
    logic     set_active;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    op_kind_e in_op;
    op_kind_e op;
    logic     slot_valid;
    logic     count_eq;
    logic     idx_last;
    logic     idx_last_in;
    logic     slot_last;
    logic     match_full;
    logic     free_any;
    ev_kind_e scan_ev;
    logic     rel_ev;
    logic     can_emit;
    logic     out_free;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/kcbm_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module kcbm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/core/kcbm_ctrl.sv =====
// controller state machine sequencing scans, lookups and result transfers
`timescale 1ns / 1ps
`default_nettype none
module kcbm_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire kcbm_pkg::stat_t  stat_i,
  output kcbm_pkg::cmd_t        cmd_o
);

  kcbm_pkg::state_e state_q, state_d;
  logic             accept;

  assign in_ready_o = (state_q == kcbm_pkg::S_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kcbm_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kcbm_pkg::S_IDLE: begin
        if (accept) begin
          unique case (stat_i.in_op)
            kcbm_pkg::OP_KEY:   state_d = kcbm_pkg::S_KEY_RD;
            kcbm_pkg::OP_CLEAR: state_d = kcbm_pkg::S_CLR;
            default:            state_d = kcbm_pkg::S_FD_SLOT;
          endcase
        end
      end
      kcbm_pkg::S_KEY_RD: state_d = kcbm_pkg::S_KEY_WR;
      kcbm_pkg::S_KEY_WR: state_d = kcbm_pkg::S_SC_SLOT;
      kcbm_pkg::S_SC_SLOT: begin
        state_d = stat_i.slot_valid ? kcbm_pkg::S_CK_KEY : kcbm_pkg::S_SC_NEXT;
      end
      kcbm_pkg::S_CK_KEY:  state_d = kcbm_pkg::S_CK_HELD;
      kcbm_pkg::S_CK_HELD: state_d = kcbm_pkg::S_CK_EVAL;
      kcbm_pkg::S_CK_EVAL: begin
        if (!stat_i.idx_last) begin
          state_d = kcbm_pkg::S_CK_KEY;
        end else if (stat_i.op == kcbm_pkg::OP_KEY) begin
          state_d = kcbm_pkg::S_SC_UPD;
        end else begin
          state_d = kcbm_pkg::S_BD_ACT;
        end
      end
      kcbm_pkg::S_SC_UPD: begin
        if (stat_i.scan_ev == kcbm_pkg::EV_NONE || stat_i.can_emit) begin
          state_d = kcbm_pkg::S_SC_NEXT;
        end
      end
      kcbm_pkg::S_SC_NEXT: begin
        state_d = stat_i.slot_last ? kcbm_pkg::S_FIN : kcbm_pkg::S_SC_SLOT;
      end
      kcbm_pkg::S_CLR: begin
        if ((!stat_i.rel_ev || stat_i.can_emit) && stat_i.slot_last) begin
          state_d = kcbm_pkg::S_FIN;
        end
      end
      kcbm_pkg::S_FD_SLOT: begin
        state_d = (stat_i.slot_valid && stat_i.count_eq) ? kcbm_pkg::S_FD_KEY
                                                         : kcbm_pkg::S_FD_NEXT;
      end
      kcbm_pkg::S_FD_KEY: state_d = kcbm_pkg::S_FD_CMP;
      kcbm_pkg::S_FD_CMP: begin
        state_d = stat_i.idx_last ? kcbm_pkg::S_FD_DEC : kcbm_pkg::S_FD_KEY;
      end
      kcbm_pkg::S_FD_DEC: begin
        state_d = stat_i.match_full ? kcbm_pkg::S_ED_REL : kcbm_pkg::S_FD_NEXT;
      end
      kcbm_pkg::S_FD_NEXT: begin
        state_d = stat_i.slot_last ? kcbm_pkg::S_ED_MISS : kcbm_pkg::S_FD_SLOT;
      end
      kcbm_pkg::S_ED_REL: begin
        if (!stat_i.rel_ev || stat_i.can_emit) begin
          state_d = (stat_i.op == kcbm_pkg::OP_UNBIND) ? kcbm_pkg::S_FIN
                                                       : kcbm_pkg::S_BD_WR;
        end
      end
      kcbm_pkg::S_ED_MISS: begin
        if (stat_i.op == kcbm_pkg::OP_BIND && stat_i.free_any) begin
          state_d = kcbm_pkg::S_BD_WR;
        end else begin
          state_d = kcbm_pkg::S_FIN;
        end
      end
      kcbm_pkg::S_BD_WR: begin
        if (stat_i.idx_last_in) begin
          state_d = kcbm_pkg::S_CK_KEY;
        end
      end
      kcbm_pkg::S_BD_ACT: state_d = kcbm_pkg::S_FIN;
      kcbm_pkg::S_FIN: begin
        if (stat_i.out_free) begin
          state_d = kcbm_pkg::S_IDLE;
        end
      end
      default: state_d = kcbm_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.emit_kind = kcbm_pkg::EV_NONE;
    unique case (state_q)
      kcbm_pkg::S_IDLE: cmd_o.load = accept;
      kcbm_pkg::S_KEY_RD: ;
      kcbm_pkg::S_KEY_WR: cmd_o.held_wr = 1'b1;
      kcbm_pkg::S_SC_SLOT: cmd_o.chk_start = stat_i.slot_valid;
      kcbm_pkg::S_CK_KEY: ;
      kcbm_pkg::S_CK_HELD: cmd_o.held_rd_ck = 1'b1;
      kcbm_pkg::S_CK_EVAL: begin
        cmd_o.eval_held = 1'b1;
        cmd_o.idx_inc   = !stat_i.idx_last;
      end
      kcbm_pkg::S_SC_UPD: begin
        if (stat_i.scan_ev == kcbm_pkg::EV_NONE || stat_i.can_emit) begin
          cmd_o.upd_active = 1'b1;
          cmd_o.emit       = (stat_i.scan_ev != kcbm_pkg::EV_NONE);
          cmd_o.emit_kind  = stat_i.scan_ev;
        end
      end
      kcbm_pkg::S_SC_NEXT: cmd_o.slot_inc = !stat_i.slot_last;
      kcbm_pkg::S_CLR: begin
        if (!stat_i.rel_ev || stat_i.can_emit) begin
          cmd_o.clr_entry = 1'b1;
          cmd_o.emit      = stat_i.rel_ev;
          cmd_o.emit_kind = kcbm_pkg::EV_RELEASE;
          cmd_o.slot_inc  = !stat_i.slot_last;
        end
      end
      kcbm_pkg::S_FD_SLOT: cmd_o.chk_start = stat_i.slot_valid && stat_i.count_eq;
      kcbm_pkg::S_FD_KEY: ;
      kcbm_pkg::S_FD_CMP: begin
        cmd_o.eval_match = 1'b1;
        cmd_o.idx_inc    = !stat_i.idx_last;
      end
      kcbm_pkg::S_FD_DEC: ;
      kcbm_pkg::S_FD_NEXT: cmd_o.slot_inc = !stat_i.slot_last;
      kcbm_pkg::S_ED_REL: begin
        if (!stat_i.rel_ev || stat_i.can_emit) begin
          cmd_o.clr_entry = 1'b1;
          cmd_o.emit      = stat_i.rel_ev;
          cmd_o.emit_kind = kcbm_pkg::EV_RELEASE;
          cmd_o.chk_start = 1'b1;
        end
      end
      kcbm_pkg::S_ED_MISS: begin
        if (stat_i.op == kcbm_pkg::OP_UNBIND) begin
          cmd_o.set_not_found = 1'b1;
        end else if (stat_i.free_any) begin
          cmd_o.take_free = 1'b1;
        end else begin
          cmd_o.set_full = 1'b1;
        end
      end
      kcbm_pkg::S_BD_WR: begin
        cmd_o.bind_wr = 1'b1;
        if (stat_i.idx_last_in) begin
          cmd_o.bind_commit = 1'b1;
          cmd_o.chk_start   = 1'b1;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      kcbm_pkg::S_BD_ACT: cmd_o.set_active = 1'b1;
      kcbm_pkg::S_FIN: cmd_o.finish = stat_i.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/kcbm_dp.sv =====
// datapath: held key bitmap, binding table, slot and key counters, result registers
`timescale 1ns / 1ps
`default_nettype none
module kcbm_dp #(
  parameter int NumBindings = kcbm_pkg::NUM_BINDINGS,
  parameter int MaxChord    = kcbm_pkg::MAX_CHORD,
  parameter int KeySpace    = kcbm_pkg::KEY_SPACE
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire kcbm_pkg::cmd_t              cmd_i,
  output kcbm_pkg::stat_t                  stat_o,
  input  wire logic [1:0]                  kind_i,
  input  wire logic                        pressed_i,
  input  wire logic [kcbm_pkg::KEY_W-1:0]  key_id_i,
  input  wire logic [2:0]                  chord_size_i,
  input  wire logic [kcbm_pkg::KEY_W-1:0]  chord_key_a_i,
  input  wire logic [kcbm_pkg::KEY_W-1:0]  chord_key_b_i,
  input  wire logic [kcbm_pkg::KEY_W-1:0]  chord_key_c_i,
  input  wire logic [kcbm_pkg::KEY_W-1:0]  chord_key_d_i,
  input  wire logic                        has_press_action_i,
  input  wire logic                        has_release_action_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [1:0]                       event_kind_o,
  output logic [kcbm_pkg::SLOT_OUT_W-1:0]  binding_slot_o,
  output logic [1:0]                       status_o,
  output logic                             last_o
);

  localparam int KeyW      = kcbm_pkg::KEY_W;
  localparam int NFields   = kcbm_pkg::KEY_FIELDS;
  localparam int Lim       = (MaxChord < NFields) ? MaxChord : NFields;
  localparam int SlotW     = (NumBindings > 1) ? $clog2(NumBindings) : 1;
  localparam int IdxW      = (MaxChord > 1) ? $clog2(MaxChord) : 1;
  localparam int CntW      = $clog2(MaxChord + 1);
  localparam int CntW1     = CntW + 1;
  localparam int HeldWords = (KeySpace + kcbm_pkg::WORD_W - 1) / kcbm_pkg::WORD_W;
  localparam int HwAw      = (HeldWords > 1) ? $clog2(HeldWords) : 1;
  localparam int ChDepth   = NumBindings * MaxChord;
  localparam int ChAw      = (ChDepth > 1) ? $clog2(ChDepth) : 1;
  localparam int WordW     = kcbm_pkg::WORD_W;
  localparam int BitW      = kcbm_pkg::BIT_W;

  // item registers
  kcbm_pkg::op_kind_e op_q;
  logic               pressed_q;
  logic [KeyW-1:0]    key_q;
  logic [KeyW-1:0]    in_keys_q [NFields];
  logic [CntW-1:0]    in_n_q;
  logic               pa_q, ra_q;
  kcbm_pkg::status_e  status_q;

  // table
  logic               slot_valid_q [NumBindings];
  logic               active_q     [NumBindings];
  logic [CntW-1:0]    count_q      [NumBindings];
  logic               pen_q        [NumBindings];
  logic               ren_q        [NumBindings];
  logic               hv_q         [HeldWords];

  // sequencing
  logic [SlotW-1:0]   slot_q;
  logic [IdxW-1:0]    idx_q;
  logic               all_held_q;
  logic [NFields-1:0] match_q;
  logic               hv_rd_q;
  logic [BitW-1:0]    ck_bit_q;
  logic               ck_inr_q;

  // results
  logic               pend_v_q;
  kcbm_pkg::ev_kind_e pend_kind_q;
  logic [SlotW-1:0]   pend_slot_q;
  logic               out_v_q;
  kcbm_pkg::ev_kind_e out_kind_q;
  logic [SlotW-1:0]   out_slot_q;
  kcbm_pkg::status_e  out_status_q;
  logic               out_last_q;

  // chord dedup at transfer
  logic [KeyW-1:0]    raw [NFields];
  logic [KeyW-1:0]    dk  [NFields];
  logic [2:0]         sz;
  logic [2:0]         dn;
  logic               dup;

  always_comb begin
    raw[0] = chord_key_a_i;
    raw[1] = chord_key_b_i;
    raw[2] = chord_key_c_i;
    raw[3] = chord_key_d_i;
    sz = chord_size_i;
    if (sz == 3'd0) begin
      sz = 3'd1;
    end
    if (sz > 3'(Lim)) begin
      sz = 3'(Lim);
    end
    dn = 3'd0;
    dup = 1'b0;
    for (int i = 0; i < NFields; i++) begin
      dk[i] = raw[i];
    end
    for (int i = 0; i < NFields; i++) begin
      if (3'(i) < sz) begin
        dup = 1'b0;
        for (int j = 0; j < i; j++) begin
          if (raw[j] == raw[i]) begin
            dup = 1'b1;
          end
        end
        if (!dup) begin
          dk[dn[1:0]] = raw[i];
          dn = dn + 3'd1;
        end
      end
    end
  end

  // held bitmap memory
  logic [HwAw-1:0]  h_raddr, h_waddr;
  logic [WordW-1:0] h_rdata, h_word, h_wdata;
  logic             h_we, key_inr;
  logic [ChAw-1:0]  c_addr;
  logic [KeyW-1:0]  c_rdata, c_wdata;
  logic [IdxW+1:0]  idx_x;

  assign key_inr = (32'(key_q) < 32'(KeySpace));
  assign h_waddr = HwAw'(key_q >> BitW);
  assign h_raddr = cmd_i.held_rd_ck ? HwAw'(c_rdata >> BitW) : h_waddr;
  assign h_word  = hv_rd_q ? h_rdata : '0;
  assign h_we    = cmd_i.held_wr & key_inr;

  always_comb begin
    h_wdata = h_word;
    h_wdata[key_q[BitW-1:0]] = pressed_q;
  end

  kcbm_ram #(.Width(WordW), .Depth(HeldWords), .AddrW(HwAw)) u_held_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  assign idx_x   = (IdxW + 2)'(idx_q);
  assign c_addr  = ChAw'(32'(slot_q) * 32'(MaxChord) + 32'(idx_q));
  assign c_wdata = in_keys_q[idx_x[1:0]];

  kcbm_ram #(.Width(KeyW), .Depth(ChDepth), .AddrW(ChAw)) u_chord_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.bind_wr),
    .waddr_i (c_addr),
    .wdata_i (c_wdata),
    .raddr_i (c_addr),
    .rdata_o (c_rdata)
  );

  // status towards the controller
  logic [CntW1-1:0]   idx_nx;
  logic [SlotW-1:0]   free_slot;
  logic               free_any;
  logic               match_full;
  logic               out_free;

  assign idx_nx   = CntW1'(idx_q) + CntW1'(1);
  assign out_free = !out_v_q || out_ready_i;

  always_comb begin
    free_slot = '0;
    free_any  = 1'b0;
    for (int s = NumBindings - 1; s >= 0; s--) begin
      if (!slot_valid_q[s]) begin
        free_slot = SlotW'(s);
        free_any  = 1'b1;
      end
    end
    match_full = 1'b1;
    for (int j = 0; j < NFields; j++) begin
      if (CntW1'(j) < CntW1'(in_n_q) && !match_q[j]) begin
        match_full = 1'b0;
      end
    end
  end

  always_comb begin
    stat_o             = '0;
    stat_o.in_op       = kcbm_pkg::op_kind_e'(kind_i);
    stat_o.op          = op_q;
    stat_o.slot_valid  = slot_valid_q[slot_q];
    stat_o.count_eq    = (count_q[slot_q] == in_n_q);
    stat_o.idx_last    = (idx_nx == CntW1'(count_q[slot_q]));
    stat_o.idx_last_in = (idx_nx == CntW1'(in_n_q));
    stat_o.slot_last   = (slot_q == SlotW'(NumBindings - 1));
    stat_o.match_full  = match_full;
    stat_o.free_any    = free_any;
    stat_o.scan_ev     = kcbm_pkg::EV_NONE;
    if (!all_held_q && active_q[slot_q] && ren_q[slot_q]) begin
      stat_o.scan_ev = kcbm_pkg::EV_RELEASE;
    end else if (all_held_q && !active_q[slot_q] && pen_q[slot_q]) begin
      stat_o.scan_ev = kcbm_pkg::EV_PRESS;
    end
    stat_o.rel_ev   = slot_valid_q[slot_q] && active_q[slot_q] && ren_q[slot_q];
    stat_o.can_emit = !pend_v_q || out_free;
    stat_o.out_free = out_free;
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= kcbm_pkg::op_kind_e'(kind_i);
      pressed_q <= pressed_i;
      key_q     <= key_id_i;
      for (int i = 0; i < NFields; i++) begin
        in_keys_q[i] <= dk[i];
      end
      in_n_q <= CntW'(dn);
      pa_q   <= has_press_action_i;
      ra_q   <= has_release_action_i;
    end
    if (cmd_i.bind_commit) begin
      count_q[slot_q] <= in_n_q;
      pen_q[slot_q]   <= pa_q;
      ren_q[slot_q]   <= ra_q;
    end
    if (cmd_i.held_rd_ck) begin
      ck_bit_q <= c_rdata[BitW-1:0];
      ck_inr_q <= (32'(c_rdata) < 32'(KeySpace));
    end
    hv_rd_q <= hv_q[h_raddr];
    if (cmd_i.chk_start) begin
      all_held_q <= 1'b1;
      match_q    <= '0;
    end else begin
      if (cmd_i.eval_held) begin
        all_held_q <= all_held_q & ck_inr_q & h_word[ck_bit_q];
      end
      if (cmd_i.eval_match) begin
        for (int j = 0; j < NFields; j++) begin
          if (CntW1'(j) < CntW1'(in_n_q) && c_rdata == in_keys_q[j]) begin
            match_q[j] <= 1'b1;
          end
        end
      end
    end
    if (cmd_i.emit) begin
      pend_kind_q <= cmd_i.emit_kind;
      pend_slot_q <= slot_q;
    end
    if (cmd_i.emit && pend_v_q) begin
      out_kind_q   <= pend_kind_q;
      out_slot_q   <= pend_slot_q;
      out_status_q <= kcbm_pkg::ST_OK;
      out_last_q   <= 1'b0;
    end else if (cmd_i.finish) begin
      out_kind_q   <= pend_v_q ? pend_kind_q : kcbm_pkg::EV_NONE;
      out_slot_q   <= pend_v_q ? pend_slot_q : '0;
      out_status_q <= pend_v_q ? kcbm_pkg::ST_OK : status_q;
      out_last_q   <= 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NumBindings; s++) begin
        slot_valid_q[s] <= 1'b0;
        active_q[s]     <= 1'b0;
      end
      for (int w = 0; w < HeldWords; w++) begin
        hv_q[w] <= 1'b0;
      end
      slot_q   <= '0;
      idx_q    <= '0;
      status_q <= kcbm_pkg::ST_OK;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (h_we) begin
        hv_q[h_waddr] <= 1'b1;
      end
      if (cmd_i.load) begin
        slot_q   <= '0;
        idx_q    <= '0;
        status_q <= kcbm_pkg::ST_OK;
      end else if (cmd_i.take_free) begin
        slot_q <= free_slot;
        idx_q  <= '0;
      end else begin
        if (cmd_i.slot_inc) begin
          slot_q <= slot_q + SlotW'(1);
        end
        if (cmd_i.chk_start) begin
          idx_q <= '0;
        end else if (cmd_i.idx_inc) begin
          idx_q <= idx_q + IdxW'(1);
        end
      end
      if (cmd_i.set_not_found) begin
        status_q <= kcbm_pkg::ST_NOT_FOUND;
      end else if (cmd_i.set_full) begin
        status_q <= kcbm_pkg::ST_TABLE_FULL;
      end
      if (cmd_i.upd_active || cmd_i.set_active) begin
        active_q[slot_q] <= all_held_q;
      end
      if (cmd_i.clr_entry) begin
        slot_valid_q[slot_q] <= 1'b0;
        active_q[slot_q]     <= 1'b0;
      end
      if (cmd_i.bind_commit) begin
        slot_valid_q[slot_q] <= 1'b1;
      end
      if (cmd_i.emit) begin
        pend_v_q <= 1'b1;
      end else if (cmd_i.finish) begin
        pend_v_q <= 1'b0;
      end
      if ((cmd_i.emit && pend_v_q) || cmd_i.finish) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_v_q;
  assign event_kind_o   = out_kind_q;
  assign binding_slot_o = kcbm_pkg::SLOT_OUT_W'(out_slot_q);
  assign status_o       = out_status_q;
  assign last_o         = out_last_q;

endmodule
`default_nettype wire

// ===== rtl/core/key_chord_binding_matcher.sv =====
// key chord binding matcher top level: controller and datapath
// one item at a time; a key event reads and updates the held-key map, then scans every
// slot, checking each bound slot's chord keys against the map, then gives its last result;
// bind/unbind walk the table comparing stored keys, bind then writes and rechecks the
// chord; clear walks every slot in turn; result transfers can stall the walk; reset
// empties the table and the held-key map at once (no clearing pass)
`timescale 1ns / 1ps
`default_nettype none
module key_chord_binding_matcher #(
  parameter int NumBindings = kcbm_pkg::NUM_BINDINGS,
  parameter int MaxChord    = kcbm_pkg::MAX_CHORD,
  parameter int KeySpace    = kcbm_pkg::KEY_SPACE
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  kind_i,
  input  wire logic                        pressed_i,
  input  wire logic [kcbm_pkg::KEY_W-1:0]  key_id_i,
  input  wire logic [2:0]                  chord_size_i,
  input  wire logic [kcbm_pkg::KEY_W-1:0]  chord_key_a_i,
  input  wire logic [kcbm_pkg::KEY_W-1:0]  chord_key_b_i,
  input  wire logic [kcbm_pkg::KEY_W-1:0]  chord_key_c_i,
  input  wire logic [kcbm_pkg::KEY_W-1:0]  chord_key_d_i,
  input  wire logic                        has_press_action_i,
  input  wire logic                        has_release_action_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [1:0]                       event_kind_o,
  output logic [kcbm_pkg::SLOT_OUT_W-1:0]  binding_slot_o,
  output logic [1:0]                       status_o,
  output logic                             last_o
);

  kcbm_pkg::cmd_t  cmd;
  kcbm_pkg::stat_t stat;

  kcbm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  kcbm_dp #(
    .NumBindings (NumBindings),
    .MaxChord    (MaxChord),
    .KeySpace    (KeySpace)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .kind_i               (kind_i),
    .pressed_i            (pressed_i),
    .key_id_i             (key_id_i),
    .chord_size_i         (chord_size_i),
    .chord_key_a_i        (chord_key_a_i),
    .chord_key_b_i        (chord_key_b_i),
    .chord_key_c_i        (chord_key_c_i),
    .chord_key_d_i        (chord_key_d_i),
    .has_press_action_i   (has_press_action_i),
    .has_release_action_i (has_release_action_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .event_kind_o         (event_kind_o),
    .binding_slot_o       (binding_slot_o),
    .status_o             (status_o),
    .last_o               (last_o)
  );

endmodule
`default_nettype wire
